// File: hdl/cafp_pkg.sv
// shared types, character codes and result codes for the candump ascii frame parser
// no dependencies
package cafp_pkg;

  localparam int unsigned FD_MAX_BYTES      = 64;
  localparam int unsigned CLASSIC_MAX_BYTES = 8;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_R = 8'h52;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_R = 8'h72;

  localparam logic [4:0] HEX_NONE = 5'd16;

  localparam logic [31:0] FLAG_EXT = 32'h8000_0000;
  localparam logic [31:0] FLAG_RTR = 32'h4000_0000;
  localparam logic [31:0] FLAG_ERR = 32'h2000_0000;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_CLASSIC   = 2'd0;
  localparam logic [1:0] ST_FD        = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        has_sum;
    logic [31:0] frame_id;
    logic [6:0]  frame_len;
    logic [3:0]  fd_flags;
    logic [1:0]  status;
  } entry_t;

  // hex digit value, HEX_NONE when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return d[4:0];
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      return d[4:0];
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + 8'd10;
      return d[4:0];
    end
    return HEX_NONE;
  endfunction

endpackage

// File: hdl/cafp_char_if.sv
// character input channel: valid/ready handshake with one text character
// no dependencies
interface cafp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_string;

  modport source (output valid, output character, output end_of_string, input ready);
  modport sink (input valid, input character, input end_of_string, output ready);
endinterface

// File: hdl/cafp_result_if.sv
// result output channel: valid/ready handshake with one data byte or frame summary
// no dependencies
interface cafp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic [31:0] frame_id;
  logic [6:0]  frame_len;
  logic [3:0]  fd_flags;
  logic [1:0]  status;
  logic        end_of_run;

  modport source (output valid, output result_kind, output data_byte, output byte_index,
                  output frame_id, output frame_len, output fd_flags, output status,
                  output end_of_run, input ready);
  modport sink (input valid, input result_kind, input data_byte, input byte_index,
                input frame_id, input frame_len, input fd_flags, input status,
                input end_of_run, output ready);
endinterface

// File: hdl/can_ascii_frame_parser.sv
// top level of the candump ascii can frame parser
// depends on cafp_pkg, cafp_char_if, cafp_result_if
//
// usage:
//   chars   - one ascii character per transfer, end_of_string on the last one
//             of a "<id>#<data>" frame text
//   results - data bytes as they complete (result_kind 0), then one frame
//             summary (result_kind 1) on the last character; end_of_run marks
//             the last result caused by a character
// the parser state is updated in the cycle a character is taken; its results
// are registered into a two-entry result queue before they appear
// a character is taken every cycle while the queue has room; a character
// that yields both a data byte and a summary presents the byte first, then
// the summary; when the receiver stalls, the queue fills and chars.ready drops
// after two pending entries; nothing is lost
// reset (rst, synchronous) returns the parser to the identifier phase and
// empties the queue
module can_ascii_frame_parser (
  input logic          clk,
  input logic          rst,
  cafp_char_if.sink    chars,
  cafp_result_if.source results
);
  import cafp_pkg::*;

  localparam logic [2:0] PH_ID          = 3'd0;
  localparam logic [2:0] PH_AFTER_DELIM = 3'd1;
  localparam logic [2:0] PH_FD_FLAGS    = 3'd2;
  localparam logic [2:0] PH_DATA_HIGH   = 3'd3;
  localparam logic [2:0] PH_DATA_LOW    = 3'd4;
  localparam logic [2:0] PH_REMOTE_DLC  = 3'd5;
  localparam logic [2:0] PH_IGNORE      = 3'd6;

  localparam logic [6:0] FD_LIMIT      = 7'(FD_MAX_BYTES);
  localparam logic [6:0] CLASSIC_LIMIT = 7'(CLASSIC_MAX_BYTES);

  logic [3:0]  char_position, char_position_next;
  logic [2:0]  parse_phase, parse_phase_next;
  logic [31:0] id_acc, id_acc_next;
  logic [3:0]  pending_high, pending_high_next;
  logic [6:0]  byte_count, byte_count_next;
  logic [3:0]  flags_nibble, flags_nibble_next;
  logic        fd_mode, fd_mode_next;
  logic        sep_skipped, sep_skipped_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic [4:0]  n;
  logic        is_hex;
  logic        emit_byte;
  logic [7:0]  new_byte;
  logic        data_high_mode;
  logic        bad;
  entry_t      new_entry;

  entry_t      queue [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        sub;
  entry_t      head;
  logic        byte_pending;
  logic        out_fire;
  logic        pop;
  logic        push;

  assign accept = chars.valid && chars.ready;
  assign n      = hex_value(chars.character);
  assign is_hex = (n != HEX_NONE);

  always_comb begin
    char_position_next = char_position;
    parse_phase_next   = parse_phase;
    id_acc_next        = id_acc;
    pending_high_next  = pending_high;
    byte_count_next    = byte_count;
    flags_nibble_next  = flags_nibble;
    fd_mode_next       = fd_mode;
    sep_skipped_next   = sep_skipped;
    error_seen_next    = error_seen;
    emit_byte          = 1'b0;
    new_byte           = {pending_high, n[3:0]};
    data_high_mode     = 1'b0;

    if (!error_seen) begin
      unique case (parse_phase)
        PH_ID: begin
          if (char_position == 4'd3 && chars.character == CH_HASH) begin
            parse_phase_next = PH_AFTER_DELIM;
          end else if (char_position >= 4'd8) begin
            if (chars.character == CH_HASH) begin
              if ((id_acc & FLAG_ERR) == 32'd0) begin
                id_acc_next = id_acc | FLAG_EXT;
              end
              parse_phase_next = PH_AFTER_DELIM;
            end else begin
              error_seen_next = 1'b1;
            end
          end else if (is_hex) begin
            id_acc_next        = {id_acc[27:0], n[3:0]};
            char_position_next = char_position + 4'd1;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        PH_AFTER_DELIM: begin
          if (chars.character == CH_UPPER_R || chars.character == CH_LOWER_R) begin
            id_acc_next      = id_acc | FLAG_RTR;
            parse_phase_next = PH_REMOTE_DLC;
          end else if (chars.character == CH_HASH) begin
            fd_mode_next     = 1'b1;
            parse_phase_next = PH_FD_FLAGS;
          end else begin
            parse_phase_next = PH_DATA_HIGH;
            data_high_mode   = 1'b1;
          end
        end
        PH_FD_FLAGS: begin
          if (is_hex) begin
            flags_nibble_next = n[3:0];
            parse_phase_next  = PH_DATA_HIGH;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        PH_DATA_HIGH: begin
          data_high_mode = 1'b1;
        end
        PH_DATA_LOW: begin
          if (is_hex) begin
            emit_byte        = 1'b1;
            byte_count_next  = byte_count + 7'd1;
            sep_skipped_next = 1'b0;
            if (byte_count_next >= (fd_mode ? FD_LIMIT : CLASSIC_LIMIT)) begin
              parse_phase_next = PH_IGNORE;
            end else begin
              parse_phase_next = PH_DATA_HIGH;
            end
          end else begin
            error_seen_next = 1'b1;
          end
        end
        PH_REMOTE_DLC: begin
          if (n <= 5'd8) begin
            byte_count_next = {3'd0, n[3:0]};
          end
          parse_phase_next = PH_IGNORE;
        end
        default: begin
        end
      endcase

      if (data_high_mode) begin
        if (chars.character == CH_DOT && !sep_skipped) begin
          sep_skipped_next = 1'b1;
        end else if (is_hex) begin
          pending_high_next = n[3:0];
          parse_phase_next  = PH_DATA_LOW;
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end

    bad = error_seen_next || parse_phase_next == PH_ID ||
          parse_phase_next == PH_FD_FLAGS || parse_phase_next == PH_DATA_LOW;

    new_entry.has_byte   = emit_byte;
    new_entry.data_byte  = new_byte;
    new_entry.byte_index = byte_count[5:0];
    new_entry.has_sum    = chars.end_of_string;
    if (bad) begin
      new_entry.frame_id  = 32'd0;
      new_entry.frame_len = 7'd0;
      new_entry.fd_flags  = 4'd0;
      new_entry.status    = ST_MALFORMED;
    end else begin
      new_entry.frame_id  = id_acc_next;
      new_entry.frame_len = byte_count_next;
      new_entry.fd_flags  = fd_mode_next ? flags_nibble_next : 4'd0;
      new_entry.status    = fd_mode_next ? ST_FD : ST_CLASSIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && chars.end_of_string)) begin
      char_position <= 4'd0;
      parse_phase   <= PH_ID;
      id_acc        <= 32'd0;
      pending_high  <= 4'd0;
      byte_count    <= 7'd0;
      flags_nibble  <= 4'd0;
      fd_mode       <= 1'b0;
      sep_skipped   <= 1'b0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      char_position <= char_position_next;
      parse_phase   <= parse_phase_next;
      id_acc        <= id_acc_next;
      pending_high  <= pending_high_next;
      byte_count    <= byte_count_next;
      flags_nibble  <= flags_nibble_next;
      fd_mode       <= fd_mode_next;
      sep_skipped   <= sep_skipped_next;
      error_seen    <= error_seen_next;
    end
  end

  // result queue
  assign head         = queue[rd_ptr];
  assign byte_pending = head.has_byte && !sub;
  assign out_fire     = results.valid && results.ready;
  assign pop          = out_fire && (!byte_pending || !head.has_sum);
  assign push         = accept && (new_entry.has_byte || new_entry.has_sum);
  assign chars.ready  = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
        sub    <= 1'b0;
      end else if (out_fire) begin
        sub <= 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_comb begin
    results.valid = (count != 2'd0);
    if (byte_pending) begin
      results.result_kind = KIND_BYTE;
      results.data_byte   = head.data_byte;
      results.byte_index  = head.byte_index;
      results.frame_id    = 32'd0;
      results.frame_len   = 7'd0;
      results.fd_flags    = 4'd0;
      results.status      = ST_CLASSIC;
      results.end_of_run  = !head.has_sum;
    end else begin
      results.result_kind = KIND_SUMMARY;
      results.data_byte   = 8'd0;
      results.byte_index  = 6'd0;
      results.frame_id    = head.frame_id;
      results.frame_len   = head.frame_len;
      results.fd_flags    = head.fd_flags;
      results.status      = head.status;
      results.end_of_run  = 1'b1;
    end
  end

endmodule
